// ===== hdl/mssc_pkg.sv =====
// Shared types, opcodes and defaults for the MIPS subset core.
`timescale 1ns / 1ps
package mssc_pkg;

  localparam int unsigned DmemBytesDef = 65536;
  localparam int unsigned QueueDepth   = 2;

  localparam logic ItemExec    = 1'b0;
  localparam logic ItemPreload = 1'b1;

  localparam logic [5:0] OpRtype = 6'h00;
  localparam logic [5:0] OpJ     = 6'h02;
  localparam logic [5:0] OpJal   = 6'h03;
  localparam logic [5:0] OpBeq   = 6'h04;
  localparam logic [5:0] OpLw    = 6'h23;
  localparam logic [5:0] OpSw    = 6'h2b;
  localparam logic [5:0] OpHalt  = 6'h3f;

  localparam logic [2:0] AluAdd = 3'd1;
  localparam logic [2:0] AluSub = 3'd3;
  localparam logic [2:0] AluAnd = 3'd4;
  localparam logic [2:0] AluOr  = 3'd5;
  localparam logic [2:0] AluNor = 3'd7;

  typedef enum logic [2:0] {
    KindPreload,
    KindHalt,
    KindJump,
    KindRtype,
    KindLoad,
    KindStore,
    KindBranch,
    KindItype
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dest;
    logic [2:0]  alu_op;
    logic [31:0] imm;
    logic [25:0] target;
    logic [15:0] pl_addr;
    logic [7:0]  pl_byte;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic        halted;
  } res_t;

endpackage

// ===== hdl/mips_subset_single_cycle_core_unit.sv =====
// Top level of the MIPS subset core: front end, decoupling queue and back end.
// The core takes one beat per clock while full is low and returns one result per
// beat, in order. A beat is queued, then passes operand read, execute and load
// completion before its result is queued; a load followed at once by an
// instruction that reads the loaded register holds that instruction back, as the
// loaded word only exists after the data memory read. After reset the data
// memory is swept to zero, one 4-byte row per cycle over all DMEM_BYTES/4 rows,
// with full held high. DMEM_BYTES must be a power of two.
`timescale 1ns / 1ps
module mips_subset_single_cycle_core_unit #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DmemBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [31:0] instruction_i,
  input  logic [15:0] preload_address_i,
  input  logic [7:0]  preload_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_written_o,
  output logic        halted_o
);
  import mssc_pkg::*;

  dec_t item;
  res_t res;
  logic avail, deq, clearing;

  mssc_front #(.DEPTH(QueueDepth)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .hold_i           (clearing),
    .opcode_i         (opcode_i),
    .instruction_i    (instruction_i),
    .preload_address_i(preload_address_i),
    .preload_byte_i   (preload_byte_i),
    .deq_i            (deq),
    .item_o           (item),
    .avail_o          (avail)
  );

  mssc_back #(.DMEM_BYTES(DMEM_BYTES), .DEPTH(QueueDepth)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .avail_i   (avail),
    .deq_o     (deq),
    .clearing_o(clearing),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign next_pc_o     = res.next_pc;
  assign reg_written_o = res.reg_written;
  assign reg_index_o   = res.reg_index;
  assign reg_value_o   = res.reg_value;
  assign mem_written_o = res.mem_written;
  assign halted_o      = res.halted;

endmodule

// ===== hdl/mssc_fifo.sv =====
// Small flop-based queue used between the core's stages.
`timescale 1ns / 1ps
module mssc_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== hdl/mssc_front.sv =====
// Front end: takes input beats, classifies the instruction and queues it.
`timescale 1ns / 1ps
module mssc_front #(
  parameter int unsigned DEPTH = mssc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          hold_i,
  input  logic          opcode_i,
  input  logic [31:0]   instruction_i,
  input  logic [15:0]   preload_address_i,
  input  logic [7:0]    preload_byte_i,
  input  logic          deq_i,
  output mssc_pkg::dec_t item_o,
  output logic          avail_o
);
  import mssc_pkg::*;

  dec_t       dec;
  logic [5:0] major;
  logic       q_full, q_empty;

  assign major = instruction_i[31:26];

  always_comb begin
    dec         = '0;
    dec.rs      = instruction_i[25:21];
    dec.rt      = instruction_i[20:16];
    dec.dest    = instruction_i[20:16];
    dec.imm     = {{16{instruction_i[15]}}, instruction_i[15:0]};
    dec.target  = instruction_i[25:0];
    dec.pl_addr = preload_address_i;
    dec.pl_byte = preload_byte_i;
    dec.alu_op  = major[2:0];
    if (opcode_i == ItemPreload) begin
      dec.kind = KindPreload;
    end else begin
      case (major)
        OpHalt: dec.kind = KindHalt;
        OpJ, OpJal: dec.kind = KindJump;
        OpRtype: begin
          dec.kind   = KindRtype;
          dec.dest   = instruction_i[15:11];
          dec.alu_op = instruction_i[2:0];
        end
        OpLw: begin
          dec.kind   = KindLoad;
          dec.alu_op = AluAdd;
        end
        OpSw: begin
          dec.kind   = KindStore;
          dec.alu_op = AluAdd;
        end
        OpBeq: dec.kind = KindBranch;
        default: dec.kind = KindItype;
      endcase
    end
  end

  assign full_o  = q_full || hold_i;
  assign avail_o = !q_empty;

  mssc_fifo #(.T(dec_t), .DEPTH(DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !full_o),
    .data_i (dec),
    .full_o (q_full),
    .pop_i  (deq_i),
    .data_o (item_o),
    .empty_o(q_empty)
  );

endmodule

// ===== hdl/mssc_back.sv =====
// Back end: operand read, execute/memory issue, load completion and result queue.
`timescale 1ns / 1ps
module mssc_back #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DmemBytesDef,
  parameter int unsigned DEPTH      = mssc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mssc_pkg::dec_t item_i,
  input  logic           avail_i,
  output logic           deq_o,
  output logic           clearing_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mssc_pkg::res_t res_o
);
  import mssc_pkg::*;

  localparam int unsigned AW   = $clog2(DMEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = DMEM_BYTES / 4;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        mw;
    logic        halted;
    logic        ld;
    logic [1:0]  off;
  } mid_t;

  function automatic logic [31:0] alu(input logic [2:0] op, input logic [31:0] x,
                                      input logic [31:0] y);
    case (op)
      AluAdd:  alu = x + y;
      AluSub:  alu = x - y;
      AluAnd:  alu = x & y;
      AluOr:   alu = x | y;
      AluNor:  alu = ~(x | y);
      default: alu = '0;
    endcase
  endfunction

  logic          clr_q;
  logic [RW-1:0] clr_row_q;
  logic          e_valid_q, m_valid_q;
  dec_t          e_q;
  mid_t          m_q, mid;
  logic [31:0]   a_q, b_q, pc_q, pc_d, pc4, b_op, alu_res, a_d, b_d, m_val, ld_word;
  logic          halt_q, halt_d;
  logic          exec, e_wr, e_st, e_ld, e_pl, hazard, take, adv, out_full;
  logic [7:0]    rdata_q [4];
  logic [31:0]   rf_mem  [32];
  logic [31:0]   rf_vld_q;

  assign adv        = !out_full && !clr_q;
  assign clearing_o = clr_q;

  // execute
  assign exec    = e_valid_q && (e_q.kind != KindPreload) && !halt_q;
  assign e_pl    = e_valid_q && (e_q.kind == KindPreload);
  assign pc4     = pc_q + 32'd4;
  assign b_op    = (e_q.kind == KindRtype) ? b_q : e_q.imm;
  assign alu_res = alu(e_q.alu_op, a_q, b_op);
  assign e_wr    = exec && (e_q.dest != 5'd0) && (e_q.kind == KindRtype ||
                   e_q.kind == KindItype || e_q.kind == KindLoad);
  assign e_st    = exec && (e_q.kind == KindStore);
  assign e_ld    = exec && (e_q.kind == KindLoad);

  always_comb begin
    pc_d   = pc_q;
    halt_d = halt_q;
    if (exec) begin
      case (e_q.kind)
        KindHalt: begin
          pc_d   = pc4;
          halt_d = 1'b1;
        end
        KindJump:   pc_d = {pc4[31:28], e_q.target, 2'b00};
        KindBranch: pc_d = (a_q == b_q) ? pc4 + {e_q.imm[29:0], 2'b00} : pc4;
        default:    pc_d = pc4;
      endcase
    end
  end

  always_comb begin
    mid         = '0;
    mid.next_pc = pc_d;
    mid.wr      = e_wr;
    mid.idx     = e_wr ? e_q.dest : 5'd0;
    mid.val     = (e_wr && !e_ld) ? alu_res : 32'd0;
    mid.mw      = e_st;
    mid.halted  = halt_d;
    mid.ld      = e_wr && e_ld;
    mid.off     = alu_res[1:0];
  end

  // four byte banks, lane k holds addresses with low bits k
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    lane;
    logic [AW-1:0] addr;
    logic [RW-1:0] row, w_row;
    logic [7:0]    w_data;
    logic          we;

    assign lane = 2'(k) - alu_res[1:0];
    assign addr = alu_res[AW-1:0] + AW'(lane);
    assign row  = addr[AW-1:2];
    assign we   = clr_q || (adv && e_st) ||
                  (adv && e_pl && (e_q.pl_addr[1:0] == 2'(k)));

    always_comb begin
      if (clr_q) begin
        w_row  = clr_row_q;
        w_data = 8'd0;
      end else if (e_pl) begin
        w_row  = e_q.pl_addr[AW-1:2];
        w_data = e_q.pl_byte;
      end else begin
        w_row  = row;
        w_data = b_q[{~lane, 3'b000} +: 8];
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) mem[w_row] <= w_data;
      if (adv && e_ld) rdata_q[k] <= mem[row];
    end
  end

  // load completion, big-endian
  assign ld_word = {rdata_q[m_q.off], rdata_q[m_q.off + 2'd1],
                    rdata_q[m_q.off + 2'd2], rdata_q[m_q.off + 2'd3]};
  assign m_val   = m_q.ld ? ld_word : m_q.val;

  // operand read with bypass; a reader of the load one ahead is held back
  assign hazard = e_ld && e_wr && (e_q.dest == item_i.rs || e_q.dest == item_i.rt);
  assign take   = avail_i && adv && !hazard;
  assign deq_o  = take;

  always_comb begin
    if (e_wr && !e_ld && e_q.dest == item_i.rs) a_d = alu_res;
    else if (m_valid_q && m_q.wr && m_q.idx == item_i.rs) a_d = m_val;
    else a_d = rf_vld_q[item_i.rs] ? rf_mem[item_i.rs] : 32'd0;
    if (e_wr && !e_ld && e_q.dest == item_i.rt) b_d = alu_res;
    else if (m_valid_q && m_q.wr && m_q.idx == item_i.rt) b_d = m_val;
    else b_d = rf_vld_q[item_i.rt] ? rf_mem[item_i.rt] : 32'd0;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      e_q <= item_i;
      a_q <= a_d;
      b_q <= b_d;
    end
    if (adv) m_q <= mid;
    if (adv && m_valid_q && m_q.wr) rf_mem[m_q.idx] <= m_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
      e_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      rf_vld_q  <= '0;
    end else begin
      if (clr_q) begin
        clr_row_q <= clr_row_q + RW'(1);
        if (clr_row_q == RW'(ROWS - 1)) clr_q <= 1'b0;
      end
      if (adv) begin
        e_valid_q <= take;
        m_valid_q <= e_valid_q;
        pc_q      <= pc_d;
        halt_q    <= halt_d;
        if (m_valid_q && m_q.wr) rf_vld_q[m_q.idx] <= 1'b1;
      end
    end
  end

  mssc_fifo #(.T(res_t), .DEPTH(DEPTH)) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv && m_valid_q),
    .data_i ({m_q.next_pc, m_q.wr, m_q.idx, m_val, m_q.mw, m_q.halted}),
    .full_o (out_full),
    .pop_i  (pop_i),
    .data_o (res_o),
    .empty_o(empty_o)
  );

endmodule

// ===== hdl/mssc_chk.sv =====
// Port-level checks on the core's results, bound to the top level.
`timescale 1ns / 1ps
module mssc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] next_pc_o,
  input logic        reg_written_o,
  input logic [4:0]  reg_index_o,
  input logic [31:0] reg_value_o,
  input logic        mem_written_o,
  input logic        halted_o
);
  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (pop && !empty && halted_o) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_halt_q) |-> halted_o) else $error("halt not sticky");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !reg_written_o) |-> (reg_index_o == 5'd0 && reg_value_o == 32'd0))
    else $error("idle write-back fields not zero");

  a_r0_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reg_written_o) |-> (reg_index_o != 5'd0)) else $error("write to r0");

  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(reg_written_o && mem_written_o)) else $error("store wrote a register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(next_pc_o))) else $error("result beat dropped");

endmodule

bind mips_subset_single_cycle_core_unit mssc_chk u_chk (.*);
